[design/tocp_pkg.sv]
// ---------------------------------------------------------------------------
// tocp_pkg
// types, constants and control structs shared by the tty output processor
// ---------------------------------------------------------------------------
`default_nettype none

package tocp_pkg;

   localparam int unsigned BUF_DEPTH_DEFAULT = 32;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned MODE_W  = 4;
   localparam int unsigned SPEC_W  = 64;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [SPEC_W-1:0] SPEC_RESET = 64'h1113_1A1C_1503_7F04;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE_FLAGS    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPECIAL_CHARS = 1'b1;

   // mode flag bits
   localparam int unsigned MODE_SIG_EN = 0;
   localparam int unsigned MODE_UPCASE = 1;
   localparam int unsigned MODE_CR2NL  = 2;
   localparam int unsigned MODE_FLOW   = 3;

   // special character slots
   localparam int unsigned SPEC_EOF   = 0;
   localparam int unsigned SPEC_ERASE = 1;
   localparam int unsigned SPEC_INTR  = 2;
   localparam int unsigned SPEC_KILL  = 3;
   localparam int unsigned SPEC_QUIT  = 4;
   localparam int unsigned SPEC_SUSP  = 5;
   localparam int unsigned SPEC_STOP  = 6;
   localparam int unsigned SPEC_START = 7;
   localparam int unsigned SPEC_NUM   = 8;

   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [BYTE_W-1:0] CHAR_LOW_A = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_LOW_Z = 8'h7A;
   localparam logic [BYTE_W-1:0] CASE_DIFF  = 8'd32;

   typedef enum logic [1:0] {
      KIND_SIGNAL = 2'd0,
      KIND_BYTE   = 2'd1,
      KIND_DONE   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      SIG_INTR = 2'd0,
      SIG_KILL = 2'd1,
      SIG_QUIT = 2'd2,
      SIG_SUSP = 2'd3
   } sig_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIG,
      ST_FETCH,
      ST_SHOW,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic     accept;
      logic     fetch;
      logic     rd_advance;
      logic     done_ack;
      kind_type out_kind;
   } ctrl_cmd_type;

   typedef struct packed {
      logic sig_emit;
      logic last_in;
      logic drain_next;
      logic drain_now;
      logic last_ff;
      logic rd_last;
   } dp_status_type;

endpackage

`default_nettype wire

[design/tocp_if.sv]
// ---------------------------------------------------------------------------
// tocp_req_if / tocp_rsp_if
// valid/ready channels of the tty output processor
// ---------------------------------------------------------------------------
`default_nettype none

interface tocp_req_if;
   logic                           valid;
   logic                           ready;
   logic [tocp_pkg::BYTE_W-1:0]    data_byte;
   logic                           last_of_write;

   modport source (output valid, output data_byte, output last_of_write, input ready);
   modport sink   (input valid, input data_byte, input last_of_write, output ready);
endinterface

interface tocp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     kind;
   logic [1:0]                     signal_code;
   logic [tocp_pkg::BYTE_W-1:0]    out_byte;
   logic [tocp_pkg::COUNT_W-1:0]   processed_count;
   logic                           last;

   modport source (output valid, output kind, output signal_code, output out_byte,
                   output processed_count, output last, input ready);
   modport sink   (input valid, input kind, input signal_code, input out_byte,
                   input processed_count, input last, output ready);
endinterface

`default_nettype wire

[design/tocp_ctrl.sv]
// ---------------------------------------------------------------------------
// tocp_ctrl
// sequencer: takes bytes, then steps through signal, drain and done results
// ---------------------------------------------------------------------------
`default_nettype none

module tocp_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   input  wire tocp_pkg::dp_status_type status,
   output tocp_pkg::ctrl_cmd_type       cmd
);

   tocp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tocp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd          = '0;
      cmd.out_kind = tocp_pkg::KIND_DONE;
      unique case (state_ff)
         tocp_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               priority if (status.sig_emit) begin
                  state_in = tocp_pkg::ST_SIG;
               end else if (status.last_in) begin
                  state_in = status.drain_next ? tocp_pkg::ST_FETCH : tocp_pkg::ST_DONE;
               end else begin
                  state_in = tocp_pkg::ST_IDLE;
               end
            end
         end
         tocp_pkg::ST_SIG: begin
            rsp_valid    = 1'b1;
            cmd.out_kind = tocp_pkg::KIND_SIGNAL;
            if (rsp_ready) begin
               priority if (!status.last_ff) begin
                  state_in = tocp_pkg::ST_IDLE;
               end else if (status.drain_now) begin
                  state_in = tocp_pkg::ST_FETCH;
               end else begin
                  state_in = tocp_pkg::ST_DONE;
               end
            end
         end
         tocp_pkg::ST_FETCH: begin
            // buffer read data lands in the next cycle
            cmd.fetch = 1'b1;
            state_in  = tocp_pkg::ST_SHOW;
         end
         tocp_pkg::ST_SHOW: begin
            rsp_valid      = 1'b1;
            cmd.out_kind   = tocp_pkg::KIND_BYTE;
            cmd.rd_advance = rsp_ready;
            if (rsp_ready) begin
               state_in = status.rd_last ? tocp_pkg::ST_DONE : tocp_pkg::ST_FETCH;
            end
         end
         tocp_pkg::ST_DONE: begin
            rsp_valid    = 1'b1;
            cmd.out_kind = tocp_pkg::KIND_DONE;
            cmd.done_ack = rsp_ready;
            if (rsp_ready) begin
               state_in = tocp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tocp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[design/tocp_datapath.sv]
// ---------------------------------------------------------------------------
// tocp_datapath
// character mapping, special character match, pending buffer and counters
// ---------------------------------------------------------------------------
`default_nettype none

module tocp_datapath #(
   parameter int unsigned BUF_DEPTH = tocp_pkg::BUF_DEPTH_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_write_enable,
   input  wire [tocp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [tocp_pkg::SPEC_W-1:0]           csr_write_data,
   input  wire [tocp_pkg::BYTE_W-1:0]           req_data_byte,
   input  wire                                  req_last_of_write,
   input  wire tocp_pkg::ctrl_cmd_type          cmd,
   output tocp_pkg::dp_status_type              status,
   output logic [1:0]                           rsp_kind,
   output logic [1:0]                           rsp_signal_code,
   output logic [tocp_pkg::BYTE_W-1:0]          rsp_out_byte,
   output logic [tocp_pkg::COUNT_W-1:0]         rsp_processed_count,
   output logic                                 rsp_last
);

   localparam int unsigned IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(BUF_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUF_DEPTH);
   localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

   logic [tocp_pkg::MODE_W-1:0]  mode_ff;
   logic [tocp_pkg::SPEC_W-1:0]  spec_ff;
   logic [tocp_pkg::BYTE_W-1:0]  pending_mem [BUF_DEPTH];
   logic [tocp_pkg::BYTE_W-1:0]  rd_data_ff;
   logic [CNT_W-1:0]             fill_ff, fill_in;
   logic [CNT_W-1:0]             rd_ptr_ff;
   logic                         oe_ff, oe_in;
   logic                         eof_ff, eof_in;
   logic [tocp_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                         last_ff;
   tocp_pkg::sig_code_type       code_ff, code_in;

   logic [tocp_pkg::BYTE_W-1:0]  c_up, c_map, store_byte;
   logic [tocp_pkg::SPEC_NUM-1:0] hit;
   logic                         active, is_sig, other, store, store_ok;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
         spec_ff <= tocp_pkg::SPEC_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tocp_pkg::CSR_MODE_FLAGS:    mode_ff <= csr_write_data[tocp_pkg::MODE_W-1:0];
            tocp_pkg::CSR_SPECIAL_CHARS: spec_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // byte mapping and special character match
   always_comb begin
      c_up = req_data_byte;
      if (mode_ff[tocp_pkg::MODE_UPCASE] && req_data_byte >= tocp_pkg::CHAR_LOW_A &&
          req_data_byte <= tocp_pkg::CHAR_LOW_Z) begin
         c_up = req_data_byte - tocp_pkg::CASE_DIFF;
      end
      c_map = c_up;
      if (mode_ff[tocp_pkg::MODE_CR2NL] && c_up == tocp_pkg::CHAR_CR) begin
         c_map = tocp_pkg::CHAR_NL;
      end
      for (int k = 0; k < tocp_pkg::SPEC_NUM; k++) begin
         hit[k] = (spec_ff[k*tocp_pkg::BYTE_W +: tocp_pkg::BYTE_W] == c_map);
      end
   end

   always_comb begin
      active = !eof_ff;
      is_sig = !hit[tocp_pkg::SPEC_EOF] && !hit[tocp_pkg::SPEC_ERASE] &&
               (hit[tocp_pkg::SPEC_INTR] || hit[tocp_pkg::SPEC_KILL] ||
                hit[tocp_pkg::SPEC_QUIT] || hit[tocp_pkg::SPEC_SUSP]);
      other  = !hit[tocp_pkg::SPEC_EOF] && !hit[tocp_pkg::SPEC_ERASE] && !is_sig &&
               !hit[tocp_pkg::SPEC_STOP] && !hit[tocp_pkg::SPEC_START];
      store  = active && !hit[tocp_pkg::SPEC_EOF] && (hit[tocp_pkg::SPEC_ERASE] || other);
      store_ok   = store && (fill_ff < DEPTH_C);
      store_byte = hit[tocp_pkg::SPEC_ERASE] ? tocp_pkg::CHAR_BS : c_map;

      priority if (hit[tocp_pkg::SPEC_INTR]) begin
         code_in = tocp_pkg::SIG_INTR;
      end else if (hit[tocp_pkg::SPEC_KILL]) begin
         code_in = tocp_pkg::SIG_KILL;
      end else if (hit[tocp_pkg::SPEC_QUIT]) begin
         code_in = tocp_pkg::SIG_QUIT;
      end else begin
         code_in = tocp_pkg::SIG_SUSP;
      end

      // flow control: stop wins over start when both match
      oe_in = oe_ff;
      if (active && mode_ff[tocp_pkg::MODE_FLOW] && !hit[tocp_pkg::SPEC_EOF] &&
          !hit[tocp_pkg::SPEC_ERASE] && !is_sig) begin
         priority if (hit[tocp_pkg::SPEC_STOP]) begin
            oe_in = 1'b0;
         end else if (hit[tocp_pkg::SPEC_START]) begin
            oe_in = 1'b1;
         end else begin
            oe_in = oe_ff;
         end
      end

      fill_in  = fill_ff + (store_ok ? ONE_C : '0);
      eof_in   = eof_ff || (active && hit[tocp_pkg::SPEC_EOF]);
      count_in = count_ff;
      if (active && !hit[tocp_pkg::SPEC_EOF] && count_ff != tocp_pkg::COUNT_MAX) begin
         count_in = count_ff + tocp_pkg::COUNT_W'(1);
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         oe_ff     <= 1'b1;
         eof_ff    <= 1'b0;
         count_ff  <= '0;
         rd_ptr_ff <= '0;
      end else if (cmd.accept) begin
         fill_ff   <= fill_in;
         oe_ff     <= oe_in;
         eof_ff    <= eof_in;
         count_ff  <= count_in;
         rd_ptr_ff <= '0;
      end else if (cmd.rd_advance) begin
         rd_ptr_ff <= rd_ptr_ff + ONE_C;
      end else if (cmd.done_ack) begin
         count_ff <= '0;
         eof_ff   <= 1'b0;
         if (oe_ff) begin
            fill_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         last_ff <= req_last_of_write;
         code_ff <= code_in;
      end
   end

   // pending buffer
   always_ff @(posedge clock) begin
      if (cmd.accept && store_ok) begin
         pending_mem[fill_ff[IDX_W-1:0]] <= store_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         rd_data_ff <= pending_mem[rd_ptr_ff[IDX_W-1:0]];
      end
   end

   always_comb begin
      status.sig_emit   = active && is_sig && mode_ff[tocp_pkg::MODE_SIG_EN];
      status.last_in    = req_last_of_write;
      status.drain_next = oe_in && (fill_in != '0);
      status.drain_now  = oe_ff && (fill_ff != '0);
      status.last_ff    = last_ff;
      status.rd_last    = ((rd_ptr_ff + ONE_C) == fill_ff);
   end

   // result payload
   always_comb begin
      rsp_kind            = cmd.out_kind;
      rsp_signal_code     = '0;
      rsp_out_byte        = '0;
      rsp_processed_count = '0;
      rsp_last            = 1'b1;
      unique case (cmd.out_kind)
         tocp_pkg::KIND_SIGNAL: begin
            rsp_signal_code = code_ff;
            rsp_last        = !last_ff;
         end
         tocp_pkg::KIND_BYTE: begin
            rsp_out_byte = rd_data_ff;
            rsp_last     = 1'b0;
         end
         tocp_pkg::KIND_DONE: begin
            rsp_processed_count = count_ff;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

[design/tty_output_char_processor_top.sv]
// ---------------------------------------------------------------------------
// tty_output_char_processor_top
// terminal write byte processor with special characters and pending buffer
// ---------------------------------------------------------------------------
//  channel   dir   protocol      contents
//  req_chan  in    valid/ready   data_byte, last_of_write
//  rsp_chan  out   valid/ready   kind, signal_code, out_byte, processed_count, last
//  csr_*     in    write only    csr_write_enable, csr_index, csr_write_data
//
//  a byte that causes no result is taken in the idle state, back to back
//  a byte with a signal result holds the input until that result is taken
//  at end of write each drained byte is read from the buffer, then shown,
//  then the done result follows; drain length is set by the fill count
//  stalls on rsp_chan hold the result and block new input; synchronous reset
// ---------------------------------------------------------------------------
`default_nettype none

module tty_output_char_processor_top #(
   parameter int unsigned BUF_DEPTH = tocp_pkg::BUF_DEPTH_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   tocp_req_if.sink                          req_chan,
   tocp_rsp_if.source                        rsp_chan,
   input  wire                               csr_write_enable,
   input  wire [tocp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [tocp_pkg::SPEC_W-1:0]        csr_write_data
);

   tocp_pkg::ctrl_cmd_type  cmd;
   tocp_pkg::dp_status_type status;

   tocp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tocp_datapath #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_data_byte       (req_chan.data_byte),
      .req_last_of_write   (req_chan.last_of_write),
      .cmd                 (cmd),
      .status              (status),
      .rsp_kind            (rsp_chan.kind),
      .rsp_signal_code     (rsp_chan.signal_code),
      .rsp_out_byte        (rsp_chan.out_byte),
      .rsp_processed_count (rsp_chan.processed_count),
      .rsp_last            (rsp_chan.last)
   );

endmodule

`default_nettype wire
